### rtl/core/sorted_union_merge_assert.svh
// Assertion macros for the sorted union merge block.
// Used by the port checker; needs no package.
`ifndef SORTED_UNION_MERGE_ASSERT_SVH
`define SORTED_UNION_MERGE_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SUM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("sorted_union_merge: property failed");

// Check that a condition never holds outside reset.
`define SUM_ASSERT_NEVER(label, clk, rst_n, cond) \
  `SUM_ASSERT(label, clk, rst_n, !(cond))

`endif

### rtl/core/sum_pkg.sv
// Shared constants and types of the sorted union merge block.
// No dependencies; used by the controller and the top level.
`default_nettype none

package sum_pkg;

  localparam int ARRAY_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int CNT_W       = $clog2(ARRAY_DEPTH + 1);
  localparam int FUNC_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START       = 2'd2;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### rtl/core/sum_ram.sv
// Single-port-write, single-port-read array store with registered read data.
// Generic; no package dependency.
`default_nettype none

module sum_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/sum_ctrl.sv
// Load and merge sequencer of the sorted union merge block: counts, pointers,
// duplicate filter and output register. Depends on sum_pkg.
`default_nettype none

module sum_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sum_pkg::FUNC_W-1:0]     func_i,
  input  wire logic signed [sum_pkg::DATA_W-1:0] element_i,
  output sum_pkg::ram_req_t                   req_a_o,
  output sum_pkg::ram_req_t                   req_b_o,
  input  wire logic [sum_pkg::DATA_W-1:0]     rd_a_i,
  input  wire logic [sum_pkg::DATA_W-1:0]     rd_b_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [sum_pkg::DATA_W-1:0]   union_value_o,
  output logic                                last_of_union_o,
  output logic                                empty_union_o,
  output logic                                overflow_seen_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FIN
  } state_e;

  localparam logic [sum_pkg::CNT_W-1:0] DEPTH_C = sum_pkg::CNT_W'(sum_pkg::ARRAY_DEPTH);
  localparam logic [sum_pkg::CNT_W-1:0] ONE_C   = sum_pkg::CNT_W'(1);

  state_e                       state_q, state_d;
  logic [sum_pkg::CNT_W-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [sum_pkg::CNT_W-1:0]    i_q, i_d, j_q, j_d;
  logic                         ovf_q, ovf_d;
  logic [sum_pkg::DATA_W-1:0]   pend_q, pend_d;
  logic                         pend_vld_q, pend_vld_d;
  logic                         out_valid_q, out_valid_d;
  logic [sum_pkg::DATA_W-1:0]   out_val_q, out_val_d;
  logic                         out_last_q, out_last_d;
  logic                         out_empty_q, out_empty_d;
  logic                         out_ovf_q, out_ovf_d;

  logic                         accept;
  logic                         out_free;
  logic                         av, bv, take_a, take_b;
  logic                         is_new, need_push;
  logic [sum_pkg::DATA_W-1:0]   cand;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign av       = i_q < cnt_a_q;
  assign bv       = j_q < cnt_b_q;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    if (av && bv) begin
      if ($signed(rd_a_i) < $signed(rd_b_i)) begin
        take_a = 1'b1;
      end else if ($signed(rd_b_i) < $signed(rd_a_i)) begin
        take_b = 1'b1;
      end else begin
        take_a = 1'b1;
        take_b = 1'b1;
      end
    end else if (av) begin
      take_a = 1'b1;
    end else begin
      take_b = 1'b1;
    end
    cand      = take_a ? rd_a_i : rd_b_i;
    is_new    = !pend_vld_q || (cand != pend_q);
    need_push = is_new && pend_vld_q;
  end

  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    i_d         = i_q;
    j_d         = j_q;
    ovf_d       = ovf_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;

    req_a_o       = '0;
    req_b_o       = '0;
    req_a_o.waddr = cnt_a_q[sum_pkg::IDX_W-1:0];
    req_a_o.wdata = element_i;
    req_a_o.raddr = i_q[sum_pkg::IDX_W-1:0];
    req_b_o.waddr = cnt_b_q[sum_pkg::IDX_W-1:0];
    req_b_o.wdata = element_i;
    req_b_o.raddr = j_q[sum_pkg::IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_i)
            sum_pkg::FUNC_LOAD_FIRST: begin
              if (cnt_a_q < DEPTH_C) begin
                req_a_o.we = 1'b1;
                cnt_a_d    = cnt_a_q + ONE_C;
              end else begin
                ovf_d = 1'b1;
              end
            end
            sum_pkg::FUNC_LOAD_SECOND: begin
              if (cnt_b_q < DEPTH_C) begin
                req_b_o.we = 1'b1;
                cnt_b_d    = cnt_b_q + ONE_C;
              end else begin
                ovf_d = 1'b1;
              end
            end
            sum_pkg::FUNC_START: begin
              i_d        = '0;
              j_d        = '0;
              pend_vld_d = 1'b0;
              state_d    = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!av && !bv) begin
          state_d = ST_FIN;
        end else if (!need_push || out_free) begin
          if (take_a) begin
            i_d = i_q + ONE_C;
          end
          if (take_b) begin
            j_d = j_q + ONE_C;
          end
          if (is_new) begin
            pend_d     = cand;
            pend_vld_d = 1'b1;
          end
          if (need_push) begin
            out_valid_d = 1'b1;
            out_val_d   = pend_q;
            out_last_d  = 1'b0;
            out_empty_d = 1'b0;
            out_ovf_d   = ovf_q;
          end
          state_d = ST_READ;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = pend_vld_q ? pend_q : '0;
          out_last_d  = 1'b1;
          out_empty_d = !pend_vld_q;
          out_ovf_d   = ovf_q;
          cnt_a_d     = '0;
          cnt_b_d     = '0;
          pend_vld_d  = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ovf_q       <= 1'b0;
      pend_q      <= '0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
      out_val_q   <= out_val_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign union_value_o   = out_val_q;
  assign last_of_union_o = out_last_q;
  assign empty_union_o   = out_empty_q;
  assign overflow_seen_o = out_ovf_q;

endmodule

`default_nettype wire

### rtl/core/sorted_union_merge.sv
// Sorted union merge: two ascending arrays of signed 32-bit words are loaded
// one word per cycle (func 0 first array, func 1 second array), each holding up
// to 32 words; further loads are dropped and set a sticky overflow flag shown on
// every result. A start word (func 2) runs a two-pointer merge and sends out the
// distinct values in ascending order, the final one marked last; with both arrays
// empty a single word flags an empty union. Input is stalled from the start word
// until the last result is in the output register. Each merge step has a read
// state, which waits on the registered read data of the two array memories, and
// a compare state. Depends on sum_pkg, sum_ram and sum_ctrl.
`default_nettype none

module sorted_union_merge (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [sum_pkg::FUNC_W-1:0]        func_i,
  input  wire logic signed [sum_pkg::DATA_W-1:0] element_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [sum_pkg::DATA_W-1:0]      union_value_o,
  output logic                                   last_of_union_o,
  output logic                                   empty_union_o,
  output logic                                   overflow_seen_o
);

  sum_pkg::ram_req_t          req_a, req_b;
  logic [sum_pkg::DATA_W-1:0] rd_a, rd_b;

  sum_ram #(
    .WIDTH (sum_pkg::DATA_W),
    .DEPTH (sum_pkg::ARRAY_DEPTH),
    .AW    (sum_pkg::IDX_W)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (req_a.we),
    .waddr_i (req_a.waddr),
    .wdata_i (req_a.wdata),
    .raddr_i (req_a.raddr),
    .rdata_o (rd_a)
  );

  sum_ram #(
    .WIDTH (sum_pkg::DATA_W),
    .DEPTH (sum_pkg::ARRAY_DEPTH),
    .AW    (sum_pkg::IDX_W)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (req_b.we),
    .waddr_i (req_b.waddr),
    .wdata_i (req_b.wdata),
    .raddr_i (req_b.raddr),
    .rdata_o (rd_b)
  );

  sum_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .element_i       (element_i),
    .req_a_o         (req_a),
    .req_b_o         (req_b),
    .rd_a_i          (rd_a),
    .rd_b_i          (rd_b),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .union_value_o   (union_value_o),
    .last_of_union_o (last_of_union_o),
    .empty_union_o   (empty_union_o),
    .overflow_seen_o (overflow_seen_o)
  );

endmodule

`default_nettype wire

### rtl/core/sum_chk.sv
// Port checker of the sorted union merge block, bound to the top level.
// Depends on sum_pkg and sorted_union_merge_assert.svh.
`default_nettype none

`include "sorted_union_merge_assert.svh"

module sum_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [sum_pkg::FUNC_W-1:0]        func_i,
  input wire logic signed [sum_pkg::DATA_W-1:0] element_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [sum_pkg::DATA_W-1:0] union_value_o,
  input wire logic                              last_of_union_o,
  input wire logic                              empty_union_o,
  input wire logic                              overflow_seen_o
);

  logic unused_in;
  assign unused_in = ^{in_valid_i, func_i, element_i};

  `SUM_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(union_value_o)
      && $stable(last_of_union_o) && $stable(empty_union_o) && $stable(overflow_seen_o))
  `SUM_ASSERT(a_empty_is_last, clk_i, rst_ni,
    out_valid_o && empty_union_o |-> last_of_union_o && (union_value_o == '0))
  `SUM_ASSERT_NEVER(a_busy_mid_union, clk_i, rst_ni,
    out_valid_o && !last_of_union_o && !in_stall_o)
  `SUM_ASSERT(a_ovf_sticky, clk_i, rst_ni,
    out_valid_o && overflow_seen_o |=> !out_valid_o || overflow_seen_o)

endmodule

bind sorted_union_merge sum_chk u_sum_chk (.*);

`default_nettype wire
